[rtl/tcse_pkg.sv]
// tcse_pkg: shared constants, opcodes and controller/datapath types
// for the text console scrollback engine; no dependencies
package tcse_pkg;

  // screen and ring geometry
  localparam int COLS               = 80;
  localparam int ROWS               = 24;
  localparam int SCROLLBACK_SCREENS = 7;
  localparam int RING_LINES         = 192;
  localparam int LIVE_OFS           = ROWS * SCROLLBACK_SCREENS;
  localparam int RING_CELLS         = RING_LINES * COLS;
  localparam int ADDR_W             = $clog2(RING_CELLS);
  localparam int LINE_W             = $clog2(RING_LINES);

  // field widths
  localparam int OP_W    = 4;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int BACK_W  = 8;
  localparam int CELL_W  = 16;
  localparam int LOC_W   = 16;
  localparam int COLOR_W = 4;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 56;
  localparam int CFG_IDX_W = 1;

  // opcodes
  localparam logic [OP_W-1:0] OP_CHAR       = 4'd0;
  localparam logic [OP_W-1:0] OP_LINE_UP    = 4'd1;
  localparam logic [OP_W-1:0] OP_LINE_DOWN  = 4'd2;
  localparam logic [OP_W-1:0] OP_PAGE_UP    = 4'd3;
  localparam logic [OP_W-1:0] OP_PAGE_DOWN  = 4'd4;
  localparam logic [OP_W-1:0] OP_VIEW_RESET = 4'd5;
  localparam logic [OP_W-1:0] OP_SET_CURSOR = 4'd6;
  localparam logic [OP_W-1:0] OP_READ       = 4'd7;
  localparam logic [OP_W-1:0] OP_LEFT       = 4'd8;
  localparam logic [OP_W-1:0] OP_RIGHT      = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 1'b1;
  localparam logic [COLOR_W-1:0]   TEXT_COLOR_RST = 4'h7;
  localparam logic [COLOR_W-1:0]   BACK_COLOR_RST = 4'h0;

  // character codes and limits
  localparam logic [CHAR_W-1:0] CHAR_NL        = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_MIN = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0720;
  localparam logic [COL_W-1:0]  LAST_COL       = 7'd79;
  localparam logic [ROW_W-1:0]  LAST_ROW       = 5'd23;
  localparam logic [BACK_W-1:0] MAX_BACK       = 8'd168;
  localparam logic [BACK_W-1:0] PAGE_LINES     = 8'd24;

  // controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic take;
    logic exec;
    logic blank_setup;
    logic blank_step;
    logic rd_capture;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic blank_last;
    logic need_scroll;
    logic is_read;
    logic out_free;
  } status_t;

endpackage

[rtl/tcse_ram.sv]
// tcse_ram: generic single-port ram with registered read data
// no dependencies
module tcse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/tcse_ctrl.sv]
// tcse_ctrl: sequencing state machine for the console engine
// depends on tcse_pkg (cmd_t, status_t)
module tcse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tcse_pkg::status_t status,
  output tcse_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_BLINE  = 3'd3;
  localparam logic [2:0] S_BLANK  = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_scroll) begin
          state_next = S_BLINE;
        end else if (status.is_read) begin
          state_next = S_RDWAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BLINE: begin
        cmd.blank_setup = 1'b1;
        state_next      = S_BLANK;
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (status.blank_last) begin
          state_next = S_DONE;
        end
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        // result goes out and the next item may come in the same cycle
        s_tready     = status.out_free;
        cmd.load_out = status.out_free;
        cmd.take     = status.out_free & s_tvalid;
        if (status.out_free) begin
          state_next = s_tvalid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/tcse_dpath.sv]
// tcse_dpath: console state, ring address unit, cell ram and output register
// depends on tcse_pkg and tcse_ram
module tcse_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  tcse_pkg::cmd_t                    cmd,
  output tcse_pkg::status_t                 status,
  input  logic [tcse_pkg::OP_W-1:0]         s_tuser,
  input  logic [tcse_pkg::IN_W-1:0]         s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tcse_pkg::OUT_W-1:0]        m_tdata,
  input  logic                              cfg_we,
  input  logic [tcse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcse_pkg::COLOR_W-1:0]      cfg_wdata
);

  localparam int LW  = tcse_pkg::LINE_W;
  localparam int AW  = tcse_pkg::ADDR_W;
  localparam int T_W = LW + 2;

  // item fields
  logic [tcse_pkg::OP_W-1:0]   in_op;
  logic [tcse_pkg::CHAR_W-1:0] in_ch;
  logic [tcse_pkg::COL_W-1:0]  in_col;
  logic [tcse_pkg::ROW_W-1:0]  in_row;

  assign in_op  = s_tuser;
  assign in_ch  = s_tdata[7:0];
  assign in_col = s_tdata[14:8];
  assign in_row = s_tdata[19:15];

  // registers
  logic [tcse_pkg::OP_W-1:0]    op_q;
  logic [tcse_pkg::CHAR_W-1:0]  ch_q;
  logic [tcse_pkg::COL_W-1:0]   col_q;
  logic [tcse_pkg::ROW_W-1:0]   row_q;
  logic [LW-1:0]                line_q;
  logic [LW-1:0]                base_line;
  logic [tcse_pkg::COL_W-1:0]   cur_col;
  logic [tcse_pkg::ROW_W-1:0]   cur_row;
  logic [tcse_pkg::BACK_W-1:0]  back_lines;
  logic [tcse_pkg::COLOR_W-1:0] fg_color;
  logic [tcse_pkg::COLOR_W-1:0] bg_color;
  logic [AW-1:0]                cnt;
  logic [tcse_pkg::CELL_W-1:0]  cell_q;
  logic                         acc_q;

  logic [tcse_pkg::CELL_W-1:0]  out_cell;
  logic [tcse_pkg::COL_W-1:0]   out_x;
  logic [tcse_pkg::ROW_W-1:0]   out_y;
  logic [tcse_pkg::LOC_W-1:0]   out_loc;
  logic [tcse_pkg::BACK_W-1:0]  out_view;
  logic                         out_acc;

  // ring line unit: (base + live offset + row - back) mod ring lines
  logic [tcse_pkg::ROW_W-1:0]  lu_row;
  logic [tcse_pkg::BACK_W-1:0] lu_back;
  logic [T_W-1:0]              lu_sum;
  logic [T_W-1:0]              lu_mod;

  always_comb begin
    if (cmd.blank_setup) begin
      lu_row  = tcse_pkg::LAST_ROW;
      lu_back = '0;
    end else if (in_op == tcse_pkg::OP_READ) begin
      lu_row  = in_row;
      lu_back = back_lines;
    end else begin
      lu_row  = cur_row;
      lu_back = '0;
    end
    lu_sum = T_W'(base_line) + T_W'(tcse_pkg::LIVE_OFS + tcse_pkg::RING_LINES)
           + T_W'(lu_row) - T_W'(lu_back);
    if (lu_sum >= T_W'(2 * tcse_pkg::RING_LINES)) begin
      lu_mod = lu_sum - T_W'(2 * tcse_pkg::RING_LINES);
    end else if (lu_sum >= T_W'(tcse_pkg::RING_LINES)) begin
      lu_mod = lu_sum - T_W'(tcse_pkg::RING_LINES);
    end else begin
      lu_mod = lu_sum;
    end
  end

  // cell address: line * 80 + column
  logic [AW-1:0] line_base;
  assign line_base = AW'({line_q, 6'b0}) + AW'({line_q, 4'b0});

  // step logic
  logic [tcse_pkg::COL_W-1:0]  col_n;
  logic [tcse_pkg::ROW_W-1:0]  row_a;
  logic [tcse_pkg::BACK_W-1:0] back_n;
  logic                        acc_n;
  logic                        char_we;
  logic                        need_scroll;
  logic                        rd_ok;
  logic [tcse_pkg::BACK_W:0]   page_sum;

  always_comb begin
    col_n    = cur_col;
    row_a    = cur_row;
    back_n   = back_lines;
    acc_n    = 1'b1;
    char_we  = 1'b0;
    page_sum = {1'b0, back_lines} + {1'b0, tcse_pkg::PAGE_LINES};
    case (op_q)
      tcse_pkg::OP_CHAR: begin
        if (ch_q == tcse_pkg::CHAR_NL) begin
          col_n = '0;
          row_a = cur_row + 1'b1;
        end else if (ch_q == tcse_pkg::CHAR_BS) begin
          if (cur_col != '0) begin
            col_n = cur_col - 1'b1;
          end
        end else if (ch_q >= tcse_pkg::CHAR_PRINT_MIN) begin
          char_we = 1'b1;
          if (cur_col == tcse_pkg::LAST_COL) begin
            col_n = '0;
            row_a = cur_row + 1'b1;
          end else begin
            col_n = cur_col + 1'b1;
          end
        end
      end
      tcse_pkg::OP_LINE_UP: begin
        if (back_lines < tcse_pkg::MAX_BACK) begin
          back_n = back_lines + 1'b1;
        end
      end
      tcse_pkg::OP_LINE_DOWN: begin
        if (back_lines != '0) begin
          back_n = back_lines - 1'b1;
        end
      end
      tcse_pkg::OP_PAGE_UP: begin
        if (back_lines >= tcse_pkg::MAX_BACK) begin
          back_n = back_lines;
        end else if (page_sum >= {1'b0, tcse_pkg::MAX_BACK}) begin
          back_n = tcse_pkg::MAX_BACK;
        end else begin
          back_n = page_sum[tcse_pkg::BACK_W-1:0];
        end
      end
      tcse_pkg::OP_PAGE_DOWN: begin
        if (back_lines < tcse_pkg::PAGE_LINES) begin
          back_n = '0;
        end else begin
          back_n = back_lines - tcse_pkg::PAGE_LINES;
        end
      end
      tcse_pkg::OP_VIEW_RESET: begin
        back_n = '0;
      end
      tcse_pkg::OP_SET_CURSOR: begin
        if (col_q > tcse_pkg::LAST_COL || row_q > tcse_pkg::LAST_ROW) begin
          acc_n = 1'b0;
        end else begin
          col_n = col_q;
          row_a = row_q;
        end
      end
      tcse_pkg::OP_LEFT: begin
        if (cur_col != '0) begin
          col_n = cur_col - 1'b1;
        end
      end
      tcse_pkg::OP_RIGHT: begin
        if (cur_col < tcse_pkg::LAST_COL) begin
          col_n = cur_col + 1'b1;
        end else begin
          col_n = '0;
          row_a = cur_row + 1'b1;
        end
      end
      default: begin
      end
    endcase
    need_scroll = row_a > tcse_pkg::LAST_ROW;
  end

  assign rd_ok = (col_q <= tcse_pkg::LAST_COL) && (row_q <= tcse_pkg::LAST_ROW);

  // ram port
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [tcse_pkg::CELL_W-1:0] ram_wdata;
  logic [tcse_pkg::CELL_W-1:0] ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = line_base + AW'(cur_col);
    ram_wdata = tcse_pkg::BLANK_CELL;
    if (cmd.clear_step) begin
      ram_we   = 1'b1;
      ram_addr = cnt;
    end else if (cmd.blank_step) begin
      ram_we   = 1'b1;
      ram_addr = line_base + AW'(cnt[tcse_pkg::COL_W-1:0]);
    end else if (cmd.exec) begin
      ram_we    = char_we;
      ram_wdata = {bg_color, fg_color, ch_q};
      if (op_q == tcse_pkg::OP_READ) begin
        ram_addr = line_base + AW'(col_q);
      end
    end
  end

  tcse_ram #(
    .WIDTH (tcse_pkg::CELL_W),
    .DEPTH (tcse_pkg::RING_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // hardware cursor location
  logic [tcse_pkg::BACK_W:0]  loc_rows;
  logic [tcse_pkg::LOC_W-1:0] loc_next;
  assign loc_rows = (tcse_pkg::BACK_W + 1)'(cur_row) + {1'b0, back_lines};
  assign loc_next = tcse_pkg::LOC_W'({loc_rows, 6'b0}) + tcse_pkg::LOC_W'({loc_rows, 4'b0})
                  + tcse_pkg::LOC_W'(cur_col) + tcse_pkg::LOC_W'(tcse_pkg::COLS);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_line  <= '0;
      cur_col    <= '0;
      cur_row    <= '0;
      back_lines <= '0;
      fg_color   <= tcse_pkg::TEXT_COLOR_RST;
      bg_color   <= tcse_pkg::BACK_COLOR_RST;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == tcse_pkg::CFG_TEXT_COLOR) begin
          fg_color <= cfg_wdata;
        end else begin
          bg_color <= cfg_wdata;
        end
      end
      if (cmd.clear_step || cmd.blank_step) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.blank_setup) begin
        cnt <= '0;
      end
      if (cmd.exec) begin
        cur_col <= col_n;
        if (need_scroll) begin
          cur_row   <= tcse_pkg::LAST_ROW;
          base_line <= (base_line == LW'(tcse_pkg::RING_LINES - 1)) ? '0
                                                                     : base_line + 1'b1;
          if (back_n == '0) begin
            back_lines <= '0;
          end else if (back_n >= tcse_pkg::MAX_BACK) begin
            back_lines <= tcse_pkg::MAX_BACK;
          end else begin
            back_lines <= back_n + 1'b1;
          end
        end else begin
          cur_row    <= row_a;
          back_lines <= back_n;
        end
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= in_op;
      ch_q  <= in_ch;
      col_q <= in_col;
      row_q <= in_row;
    end
    if (cmd.take || cmd.blank_setup) begin
      line_q <= lu_mod[LW-1:0];
    end
    if (cmd.exec) begin
      cell_q <= '0;
      acc_q  <= acc_n;
    end else if (cmd.rd_capture) begin
      cell_q <= rd_ok ? ram_rdata : '0;
    end
    if (cmd.load_out) begin
      out_cell <= cell_q;
      out_x    <= cur_col;
      out_y    <= cur_row;
      out_loc  <= loc_next;
      out_view <= back_lines;
      out_acc  <= acc_q;
    end
  end

  assign m_tdata = {3'b0, out_acc, out_view, out_loc, out_y, out_x, out_cell};

  assign status.clear_last  = (cnt == AW'(tcse_pkg::RING_CELLS - 1));
  assign status.blank_last  = (cnt[tcse_pkg::COL_W-1:0] == tcse_pkg::LAST_COL);
  assign status.need_scroll = need_scroll;
  assign status.is_read     = (op_q == tcse_pkg::OP_READ);
  assign status.out_free    = !m_tvalid || m_tready;

endmodule

[rtl/text_console_scrollback_engine_top.sv]
// text_console_scrollback_engine_top: 80x24 text console over a scrollback line ring
// depends on tcse_pkg, tcse_ctrl, tcse_dpath (and tcse_ram below it)
//
// usage
//   input channel s_*: one item per command (print byte, scroll keys, set cursor,
//   cell read, cursor left/right), the opcode on s_tuser. output channel m_*: exactly
//   one result item per input item, in order, carrying the read cell, cursor, cursor
//   location register value, view offset and an accepted flag.
//   cfg_*: color registers (index 0 text color, index 1 back color), written while
//   the engine is idle; writes take effect at once and are taken in every state.
// operation
//   a print, cursor or view op is executed and its result registered; a cell read adds
//   a registered ram read, and an item that advances the ring also blanks the new bottom
//   line one cell per cycle (80 cells) through the single cell ram port. the engine
//   handles one item at a time; loading a result and accepting the next share a cycle.
// reset
//   rst is synchronous. after it the engine sweeps all 15360 ring cells to blank, one
//   cell a cycle; s_tready stays low during the sweep.
// stalls
//   a result waits in the output register while m_tready is low; one more item may
//   be accepted and worked, then the engine holds until the register drains.
module text_console_scrollback_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // op[3:0]
  input  logic [tcse_pkg::OP_W-1:0]           s_tuser,
  // char_code[7:0], col[14:8], row[19:15], zero fill [23:20]
  input  logic [tcse_pkg::IN_W-1:0]           s_tdata,
  // cell_value[15:0], cursor_x[22:16], cursor_y[27:23], cursor_location[43:28],
  // view_offset[51:44], accepted[52], zero fill [55:53]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tcse_pkg::OUT_W-1:0]          m_tdata,
  // color register writes
  input  logic                                cfg_we,
  input  logic [tcse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcse_pkg::COLOR_W-1:0]        cfg_wdata
);

  tcse_pkg::cmd_t    cmd;
  tcse_pkg::status_t status;

  // sequencing: clear sweep, accept, execute, blank line, read wait, result
  tcse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // console state, ring addressing, cell memory and output register
  tcse_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

[rtl/tcse_checker.sv]
// tcse_checker: port-level assertions for the console engine, bound to the top level
// depends on tcse_pkg
module tcse_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [tcse_pkg::OUT_W-1:0]   m_tdata
);

  logic [tcse_pkg::COL_W-1:0]  chk_x;
  logic [tcse_pkg::ROW_W-1:0]  chk_y;
  logic [tcse_pkg::LOC_W-1:0]  chk_loc;
  logic [tcse_pkg::BACK_W-1:0] chk_view;
  logic [tcse_pkg::LOC_W-1:0]  chk_loc_calc;

  assign chk_x    = m_tdata[22:16];
  assign chk_y    = m_tdata[27:23];
  assign chk_loc  = m_tdata[43:28];
  assign chk_view = m_tdata[51:44];
  assign chk_loc_calc = (tcse_pkg::LOC_W'(chk_y) + tcse_pkg::LOC_W'(chk_view))
                        * tcse_pkg::LOC_W'(tcse_pkg::COLS)
                      + tcse_pkg::LOC_W'(chk_x) + tcse_pkg::LOC_W'(tcse_pkg::COLS);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_x <= tcse_pkg::LAST_COL && chk_y <= tcse_pkg::LAST_ROW)
    else $error("cursor off screen");

  // scrollback view saturates
  a_view_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_view <= tcse_pkg::MAX_BACK)
    else $error("view offset beyond scrollback limit");

  // cursor location register agrees with reported cursor and view
  a_loc_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_loc == chk_loc_calc)
    else $error("cursor location mismatch");

endmodule

bind text_console_scrollback_engine_top tcse_checker u_tcse_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
